[design/whpse_pkg.sv]
// ----------------------------------------------------------------------------
// WAVE header parser package
// Shared codes, tags and item types for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package whpse_pkg;

   localparam int unsigned MaxBlockBytes = 4;

   // Input opcodes
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_NEW  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_SHORT_HEADER = 3'd0;
   localparam logic [2:0] ERR_NOT_RIFF     = 3'd1;
   localparam logic [2:0] ERR_SHORT_FMT    = 3'd2;
   localparam logic [2:0] ERR_NO_FMT_TAG   = 3'd3;
   localparam logic [2:0] ERR_UNSUPPORTED  = 3'd4;
   localparam logic [2:0] ERR_SHORT_DATA   = 3'd5;
   localparam logic [2:0] ERR_NO_DATA_TAG  = 3'd6;
   localparam logic [2:0] ERR_TRUNCATED    = 3'd7;

   // Chunk tags, first byte of the file in the top bits
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FMT_PCM     = 16'h0001;
   localparam logic [15:0] BITS_MAX    = 16'd16;
   localparam logic [15:0] BITS_EIGHT  = 16'd8;
   localparam logic [31:0] FMT_LEN_STD = 32'd16;
   localparam logic [7:0]  SIGN_FLIP   = 8'h80;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] file_byte;
   } whpse_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  sample;
      logic [31:0] rate;
      logic [2:0]  err;
      logic        last;
   } whpse_result_type;

endpackage

[design/whpse_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the parser takes it.
// ----------------------------------------------------------------------------
module whpse_in_stage
   import whpse_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic [1:0]     req_tuser,
   input  logic           take,
   output logic           item_valid,
   output whpse_item_type item
);

   logic           valid_ff, valid_in;
   whpse_item_type item_ff;

   assign req_tready = !valid_ff || take;

   always_comb begin
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         item_ff.opcode    <= req_tuser;
         item_ff.file_byte <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/whpse_parser.sv]
// ----------------------------------------------------------------------------
// Header parser
// Walks the RIFF, fmt and data headers one byte per item and extracts the
// left-channel sample of each whole block.
// ----------------------------------------------------------------------------
module whpse_parser
   import whpse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  whpse_item_type   item,
   output logic             res_valid,
   output whpse_result_type res
);

   typedef enum logic [2:0] {
      PH_RIFF = 3'd0,
      PH_FMT  = 3'd1,
      PH_SKIP = 3'd2,
      PH_DHDR = 3'd3,
      PH_SAMP = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic        tag_bad_ff, tag_bad_in;
   logic [31:0] fmt_len_ff, fmt_len_in;
   logic [15:0] format_ff, format_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bps_ff, bps_in;
   logic [15:0] block_ff, block_in;
   logic [31:0] dlen_ff, dlen_in;
   logic [31:0] remain_ff, remain_in;
   logic [2:0]  bib_ff, bib_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;

   logic [7:0]  b;
   logic [31:0] tag_shifted;
   logic [31:0] count_inc;
   logic [15:0] bps_full;
   logic [31:0] dlen_full;
   logic [31:0] block_wide;
   logic [31:0] remain_sub;
   logic        unsupported;

   assign b           = item.file_byte;
   assign tag_shifted = {tag_ff[23:0], b};
   assign count_inc   = count_ff + 32'd1;
   assign bps_full    = {b, bps_ff[7:0]};
   assign dlen_full   = {b, dlen_ff[23:0]};
   assign block_wide  = {16'd0, block_ff};
   assign remain_sub  = remain_ff - block_wide;

   assign unsupported = (format_ff != FMT_PCM) || (bps_full > BITS_MAX) ||
                        (fmt_len_ff < FMT_LEN_STD) || (block_ff == 16'd0) ||
                        (block_ff > 16'(MaxBlockBytes)) ||
                        ((bps_full != BITS_EIGHT) && (block_ff < 16'd2));

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      tag_in     = tag_ff;
      tag_bad_in = tag_bad_ff;
      fmt_len_in = fmt_len_ff;
      format_in  = format_ff;
      rate_in    = rate_ff;
      bps_in     = bps_ff;
      block_in   = block_ff;
      dlen_in    = dlen_ff;
      remain_in  = remain_ff;
      bib_in     = bib_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      res_valid  = 1'b0;
      res        = '0;

      if (take) begin
         case (item.opcode)
            OP_NEW: begin
               phase_in   = PH_RIFF;
               count_in   = '0;
               tag_in     = '0;
               tag_bad_in = 1'b0;
               bib_in     = '0;
            end
            OP_END: begin
               res.kind = KIND_ERROR;
               case (phase_ff)
                  PH_RIFF: begin
                     res_valid = 1'b1;
                     res.err   = ERR_SHORT_HEADER;
                  end
                  PH_FMT: begin
                     res_valid = 1'b1;
                     res.err   = ERR_SHORT_FMT;
                  end
                  PH_SKIP, PH_DHDR: begin
                     res_valid = 1'b1;
                     res.err   = ERR_SHORT_DATA;
                  end
                  PH_SAMP: begin
                     res_valid = 1'b1;
                     res.err   = ERR_TRUNCATED;
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
               if (res_valid) begin
                  phase_in = PH_DONE;
               end
            end
            OP_BYTE: begin
               case (phase_ff)
                  PH_RIFF: begin
                     tag_in = tag_shifted;
                     if (count_ff == 32'd3 && tag_shifted != TAG_RIFF) begin
                        tag_bad_in = 1'b1;
                     end
                     if (count_ff == 32'd11) begin
                        if (tag_shifted != TAG_WAVE || tag_bad_ff) begin
                           res_valid = 1'b1;
                           res.kind  = KIND_ERROR;
                           res.err   = ERR_NOT_RIFF;
                           phase_in  = PH_DONE;
                        end else begin
                           phase_in = PH_FMT;
                           count_in = '0;
                           tag_in   = '0;
                        end
                     end else begin
                        count_in = count_inc;
                     end
                  end
                  PH_FMT: begin
                     // Little-endian fields land in the byte lane given by the offset.
                     if (count_ff < 32'd4) begin
                        tag_in = tag_shifted;
                        if (count_ff == 32'd3 && tag_shifted != TAG_FMT) begin
                           tag_bad_in = 1'b1;
                        end
                     end else if (count_ff < 32'd8) begin
                        fmt_len_in[{count_ff[1:0], 3'b000} +: 8] = b;
                     end else if (count_ff < 32'd10) begin
                        format_in[{count_ff[0], 3'b000} +: 8] = b;
                     end else if (count_ff >= 32'd12 && count_ff < 32'd16) begin
                        rate_in[{count_ff[1:0], 3'b000} +: 8] = b;
                     end else if (count_ff >= 32'd20 && count_ff < 32'd22) begin
                        block_in[{count_ff[0], 3'b000} +: 8] = b;
                     end else if (count_ff >= 32'd22) begin
                        bps_in[{count_ff[0], 3'b000} +: 8] = b;
                     end
                     if (count_ff == 32'd23) begin
                        if (tag_bad_ff) begin
                           res_valid = 1'b1;
                           res.kind  = KIND_ERROR;
                           res.err   = ERR_NO_FMT_TAG;
                           phase_in  = PH_DONE;
                        end else if (unsupported) begin
                           res_valid = 1'b1;
                           res.kind  = KIND_ERROR;
                           res.err   = ERR_UNSUPPORTED;
                           phase_in  = PH_DONE;
                        end else begin
                           count_in = '0;
                           tag_in   = '0;
                           phase_in = (fmt_len_ff == FMT_LEN_STD) ? PH_DHDR : PH_SKIP;
                        end
                     end else begin
                        count_in = count_inc;
                     end
                  end
                  PH_SKIP: begin
                     if (count_inc == fmt_len_ff - FMT_LEN_STD) begin
                        count_in = '0;
                        phase_in = PH_DHDR;
                     end else begin
                        count_in = count_inc;
                     end
                  end
                  PH_DHDR: begin
                     if (count_ff < 32'd4) begin
                        tag_in = tag_shifted;
                        if (count_ff == 32'd3 && tag_shifted != TAG_DATA) begin
                           tag_bad_in = 1'b1;
                        end
                     end else begin
                        dlen_in[{count_ff[1:0], 3'b000} +: 8] = b;
                     end
                     if (count_ff == 32'd7) begin
                        res_valid = 1'b1;
                        if (tag_bad_ff) begin
                           res.kind = KIND_ERROR;
                           res.err  = ERR_NO_DATA_TAG;
                           phase_in = PH_DONE;
                        end else begin
                           count_in  = '0;
                           remain_in = dlen_full;
                           res.kind  = KIND_HEADER;
                           res.rate  = rate_ff;
                           // No whole block in the data: the header is the last item.
                           if (dlen_full < block_wide) begin
                              res.last = 1'b1;
                              phase_in = PH_DONE;
                           end else begin
                              phase_in = PH_SAMP;
                           end
                        end
                     end else begin
                        count_in = count_inc;
                     end
                  end
                  PH_SAMP: begin
                     if (bib_ff == 3'd0) begin
                        held0_in = b;
                     end
                     if (bib_ff == 3'd1) begin
                        held1_in = b;
                     end
                     if ({13'd0, bib_ff} + 16'd1 == block_ff) begin
                        bib_in    = '0;
                        remain_in = remain_sub;
                        res_valid = 1'b1;
                        res.kind  = KIND_SAMPLE;
                        res.sample = (bps_ff == BITS_EIGHT) ? held0_in
                                                            : (held1_in ^ SIGN_FLIP);
                        res.last  = (remain_sub < block_wide);
                        if (res.last) begin
                           phase_in = PH_DONE;
                        end
                     end else begin
                        bib_in = bib_ff + 3'd1;
                     end
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_RIFF;
         count_ff   <= '0;
         tag_ff     <= '0;
         tag_bad_ff <= 1'b0;
         bib_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         tag_ff     <= tag_in;
         tag_bad_ff <= tag_bad_in;
         bib_ff     <= bib_in;
      end
      fmt_len_ff <= fmt_len_in;
      format_ff  <= format_in;
      rate_ff    <= rate_in;
      bps_ff     <= bps_in;
      block_ff   <= block_in;
      dlen_ff    <= dlen_in;
      remain_ff  <= remain_in;
      held0_ff   <= held0_in;
      held1_ff   <= held1_in;
   end

endmodule

[design/whpse_out_stage.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module whpse_out_stage
   import whpse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  whpse_result_type res,
   output logic             space,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic             valid_ff, valid_in;
   whpse_result_type res_ff;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.err, res_ff.rate, res_ff.sample};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;

endmodule

[design/wav_header_parse_sample_extract.sv]
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser and sample extractor
// Checks a PCM WAVE header byte by byte, reports the sampling rate and
// emits the left-channel sample of each whole block as an unsigned byte.
// ----------------------------------------------------------------------------
//   channel | direction | contents
//   req_    | in        | tdata: file_byte[7:0]; tuser: opcode[1:0]
//   rsp_    | out       | tdata: sample_value[7:0], rate_hz[39:8],
//           |           |        error_code[42:40]; tuser: result_kind;
//           |           |        tlast: last_sample
//
// One item a cycle is accepted unless a stalled result holds the input register;
// the parser reads it from there and registers any result in the result register.
// Synchronous reset returns the parser to the RIFF header; no clearing pass.
// A stalled result holds the parser, which holds the input register; an
// item that gives no result still waits for space in the result register.
// ----------------------------------------------------------------------------
module wav_header_parse_sample_extract
   import whpse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // file_byte[7:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // sample_value[7:0], rate_hz[39:8], error_code[42:40]
   output logic [1:0]  rsp_tuser,   // result_kind[1:0]
   output logic        rsp_tlast
);

   logic             item_valid;
   whpse_item_type   item;
   logic             take;
   logic             space;
   logic             res_valid;
   whpse_result_type res;

   assign take = item_valid && space;

   whpse_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   whpse_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   whpse_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && res_valid),
      .res        (res),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // With an empty result register the input side never stalls.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result register");

   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> !rsp_tlast && rsp_tdata[39:0] == 40'd0)
      else $error("error item carries sample, rate or last flag");

   a_sample_no_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SAMPLE |-> rsp_tdata[47:8] == 40'd0)
      else $error("sample item carries rate or error code");

   a_header_no_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HEADER |-> rsp_tdata[7:0] == 8'd0
         && rsp_tdata[42:40] == ERR_SHORT_HEADER)
      else $error("header item carries sample or error code");

endmodule
